// File: rtl/ihc_pkg.sv
// ----------------------------------------------------------------------------
// ihc_pkg
// Item types and character constants for the IPv4-or-hostname classifier.
// ----------------------------------------------------------------------------
package ihc_pkg;

    // One byte of a target name
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    // One verdict per name
    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] ipv4_address;
    } result_item_t;

    // Verdict codes
    localparam logic [1:0] VERDICT_IPV4_OK  = 2'd0;
    localparam logic [1:0] VERDICT_IPV4_BAD = 2'd1;
    localparam logic [1:0] VERDICT_HOST_OK  = 2'd2;
    localparam logic [1:0] VERDICT_INVALID  = 2'd3;

    // Syntax limits
    localparam logic [7:0] MAX_NAME_LEN  = 8'd253;
    localparam logic [6:0] MAX_LABEL_LEN = 7'd63;
    localparam logic [2:0] QUAD_DOTS     = 3'd3;

    // Saturation points of the running counters
    localparam logic [7:0] NAME_LEN_SAT  = 8'd255;
    localparam logic [6:0] LABEL_LEN_SAT = 7'd127;
    localparam logic [2:0] DOT_SAT       = 3'd7;
    localparam logic [1:0] DIGIT_SAT     = 2'd3;

    // Character codes
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

endpackage

// File: rtl/ipv4_or_hostname_classifier.sv
// ----------------------------------------------------------------------------
// ipv4_or_hostname_classifier
// Streams a target name in byte by byte and classifies it as a dotted-quad
// IPv4 address, a malformed IPv4 literal, a valid hostname or an invalid name.
// ----------------------------------------------------------------------------
// Usage:
//   char channel   : one byte of the name per item, last_char marks the end.
//   result channel : one item per name, sent after the item with last_char.
//   Each byte updates a small set of running counters and flags held in
//   registers; the verdict is formed in the same cycle as the last byte and
//   lands in the result register.
//   result_valid rises in the cycle after the last byte is accepted.
//   Throughput: one byte per cycle; the next name may start right after the
//   last byte of the previous one. The rate is set by the result register:
//   a byte is taken while the register is empty or being drained.
//   Stall: while a verdict sits unaccepted in the result register, char_ready
//   is low and no byte is taken; bytes and verdicts are never lost.
//   Reset: all counters and flags clear, the result register empties.
//   ipv4_address reads zero unless the verdict is a valid IPv4 address.
// ----------------------------------------------------------------------------
module ipv4_or_hostname_classifier
    import ihc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    output logic         char_ready,
    input  char_item_t   char_data,
    output logic         result_valid,
    input  logic         result_ready,
    output result_item_t result_data
);

    // Running state
    logic [7:0]  name_length_reg,      name_length_next;
    logic [6:0]  label_length_reg,     label_length_next;
    logic [7:0]  previous_char_reg,    previous_char_next;
    logic        first_is_digit_reg,   first_is_digit_next;
    logic [2:0]  dot_count_reg,        dot_count_next;
    logic        letter_since_dot_reg, letter_since_dot_next;
    logic        hostname_bad_reg,     hostname_bad_next;
    logic        ipv4_bad_reg,         ipv4_bad_next;
    logic [8:0]  octet_value_reg,      octet_value_next;
    logic [1:0]  octet_digits_reg,     octet_digits_next;
    logic [31:0] address_reg,          address_next;

    // Result register
    logic         result_valid_reg, result_valid_next;
    result_item_t result_data_reg,  result_data_next;

    logic        accept;
    logic [7:0]  c;
    logic        is_digit;
    logic        is_letter;
    logic [11:0] octet_times_ten;
    logic [11:0] octet_sum;
    logic        ip_ok;
    logic        host_ok;
    logic [31:0] final_address;

    assign char_ready = !result_valid_reg || result_ready;
    assign accept     = char_valid && char_ready;
    assign c          = char_data.char_code;

    assign is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign is_letter = ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
                       ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));

    // value*10 + digit, as two shifted adds
    assign octet_times_ten = {octet_value_reg, 3'b000} + {2'b00, octet_value_reg, 1'b0};
    assign octet_sum       = octet_times_ten + {8'd0, c[3:0]};

    // Per-byte update of the counters and flags
    always_comb
    begin
        name_length_next      = name_length_reg;
        label_length_next     = label_length_reg;
        first_is_digit_next   = first_is_digit_reg;
        dot_count_next        = dot_count_reg;
        letter_since_dot_next = letter_since_dot_reg;
        hostname_bad_next     = hostname_bad_reg;
        ipv4_bad_next         = ipv4_bad_reg;
        octet_value_next      = octet_value_reg;
        octet_digits_next     = octet_digits_reg;
        address_next          = address_reg;
        previous_char_next    = c;

        if (name_length_reg == 8'd0)
        begin
            first_is_digit_next = is_digit;
        end
        if (name_length_reg != NAME_LEN_SAT)
        begin
            name_length_next = name_length_reg + 8'd1;
        end

        if (c == CHAR_DOT)
        begin
            // close a label and an octet
            if ((label_length_reg == 7'd0) || (label_length_reg > MAX_LABEL_LEN) ||
                (previous_char_reg == CHAR_HYPHEN))
            begin
                hostname_bad_next = 1'b1;
            end
            label_length_next     = 7'd0;
            letter_since_dot_next = 1'b0;
            if ((octet_digits_reg == 2'd0) || (dot_count_reg >= QUAD_DOTS))
            begin
                ipv4_bad_next = 1'b1;
            end
            address_next      = {address_reg[23:0], octet_value_reg[7:0]};
            octet_value_next  = 9'd0;
            octet_digits_next = 2'd0;
            if (dot_count_reg != DOT_SAT)
            begin
                dot_count_next = dot_count_reg + 3'd1;
            end
        end
        else if (c == CHAR_HYPHEN)
        begin
            if (label_length_reg == 7'd0)
            begin
                hostname_bad_next = 1'b1;
            end
            if (label_length_reg != LABEL_LEN_SAT)
            begin
                label_length_next = label_length_reg + 7'd1;
            end
            ipv4_bad_next = 1'b1;
        end
        else if (is_digit || is_letter)
        begin
            if (label_length_reg != LABEL_LEN_SAT)
            begin
                label_length_next = label_length_reg + 7'd1;
            end
            if (is_letter)
            begin
                letter_since_dot_next = 1'b1;
                ipv4_bad_next         = 1'b1;
            end
            else
            begin
                // leading zero, or octet over 255
                if ((octet_digits_reg != 2'd0) && (octet_value_reg == 9'd0))
                begin
                    ipv4_bad_next = 1'b1;
                end
                if (octet_sum > 12'd255)
                begin
                    ipv4_bad_next = 1'b1;
                end
                else
                begin
                    octet_value_next = octet_sum[8:0];
                end
                if (octet_digits_reg != DIGIT_SAT)
                begin
                    octet_digits_next = octet_digits_reg + 2'd1;
                end
            end
        end
        else
        begin
            hostname_bad_next = 1'b1;
            ipv4_bad_next     = 1'b1;
        end
    end

    // Verdict from the state after the last byte
    assign ip_ok = !ipv4_bad_next && (octet_digits_next != 2'd0) &&
                   (dot_count_next == QUAD_DOTS);
    assign host_ok = !hostname_bad_next && (name_length_next <= MAX_NAME_LEN) &&
                     (label_length_next != 7'd0) && (label_length_next <= MAX_LABEL_LEN) &&
                     (c != CHAR_HYPHEN) &&
                     !((dot_count_next != 3'd0) && !letter_since_dot_next);
    assign final_address = {address_next[23:0], octet_value_next[7:0]};

    always_comb
    begin
        result_data_next.ipv4_address = 32'd0;
        if (ip_ok)
        begin
            result_data_next.verdict      = VERDICT_IPV4_OK;
            result_data_next.ipv4_address = final_address;
        end
        else if ((dot_count_next == QUAD_DOTS) && first_is_digit_next && is_digit)
        begin
            result_data_next.verdict = VERDICT_IPV4_BAD;
        end
        else if (host_ok)
        begin
            result_data_next.verdict = VERDICT_HOST_OK;
        end
        else
        begin
            result_data_next.verdict = VERDICT_INVALID;
        end
    end

    // Result register load / drain
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (accept && char_data.last_char)
        begin
            result_valid_next = 1'b1;
        end
    end

    // State registers; the running counters and flags clear after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_length_reg      <= 8'd0;
            label_length_reg     <= 7'd0;
            previous_char_reg    <= 8'd0;
            first_is_digit_reg   <= 1'b0;
            dot_count_reg        <= 3'd0;
            letter_since_dot_reg <= 1'b0;
            hostname_bad_reg     <= 1'b0;
            ipv4_bad_reg         <= 1'b0;
            octet_value_reg      <= 9'd0;
            octet_digits_reg     <= 2'd0;
            address_reg          <= 32'd0;
            result_valid_reg     <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (accept)
            begin
                if (char_data.last_char)
                begin
                    name_length_reg      <= 8'd0;
                    label_length_reg     <= 7'd0;
                    previous_char_reg    <= 8'd0;
                    first_is_digit_reg   <= 1'b0;
                    dot_count_reg        <= 3'd0;
                    letter_since_dot_reg <= 1'b0;
                    hostname_bad_reg     <= 1'b0;
                    ipv4_bad_reg         <= 1'b0;
                    octet_value_reg      <= 9'd0;
                    octet_digits_reg     <= 2'd0;
                    address_reg          <= 32'd0;
                end
                else
                begin
                    name_length_reg      <= name_length_next;
                    label_length_reg     <= label_length_next;
                    previous_char_reg    <= previous_char_next;
                    first_is_digit_reg   <= first_is_digit_next;
                    dot_count_reg        <= dot_count_next;
                    letter_since_dot_reg <= letter_since_dot_next;
                    hostname_bad_reg     <= hostname_bad_next;
                    ipv4_bad_reg         <= ipv4_bad_next;
                    octet_value_reg      <= octet_value_next;
                    octet_digits_reg     <= octet_digits_next;
                    address_reg          <= address_next;
                end
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && char_data.last_char)
        begin
            result_data_reg <= result_data_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

`ifndef SYNTHESIS
    // address is only reported with a valid IPv4 verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_data.verdict != VERDICT_IPV4_OK)) |->
        (result_data.ipv4_address == 32'd0))
        else $error("ipv4_address nonzero without IPv4 verdict");

    // last byte always produces a verdict next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && char_data.last_char) |=> result_valid)
        else $error("missing verdict after last byte");

    // a middle byte never creates a verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !char_data.last_char) |=> !result_valid)
        else $error("verdict produced by a middle byte");

    // state is cleared once a name is finished
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && char_data.last_char) |=>
        ((name_length_reg == 8'd0) && (dot_count_reg == 3'd0) && (address_reg == 32'd0)))
        else $error("state not cleared after last byte");
`endif

endmodule

// File: sim/ihc_verdict_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ihc_verdict_checker
// Watches both channels of the classifier, keeps its own running copy of the
// per-byte counters and flags, works out the verdict for every finished name
// and compares each verdict item that leaves the block against it.
// ----------------------------------------------------------------------------
module ihc_verdict_checker
    import ihc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    input  logic         char_ready,
    input  char_item_t   char_data,
    input  logic         result_valid,
    input  logic         result_ready,
    input  result_item_t result_data,
    output int           fail_count,
    output int           verdicts_owed
);

    // Running state of the name being classified
    logic [7:0]  name_len;
    logic [6:0]  label_cnt;
    logic [7:0]  prev_char;
    logic        first_digit;
    logic [2:0]  dots;
    logic        letter_seen;
    logic        host_bad;
    logic        ip_bad;
    logic [8:0]  octet_val;
    logic [1:0]  octet_cnt;
    logic [31:0] addr_acc;

    // Verdicts worked out but not yet seen on the result channel
    result_item_t expected_verdicts[$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic clear_name_state();
        name_len    = '0;
        label_cnt   = '0;
        prev_char   = '0;
        first_digit = 1'b0;
        dots        = '0;
        letter_seen = 1'b0;
        host_bad    = 1'b0;
        ip_bad      = 1'b0;
        octet_val   = '0;
        octet_cnt   = '0;
        addr_acc    = '0;
    endtask

    // Fold one byte into the running state; on the final byte form the verdict
    task automatic classify_byte(input char_item_t it, output bit done,
                                 output result_item_t res);
        logic [7:0] c;
        logic       is_num;
        logic       is_alpha;
        logic       ip_ok;
        logic       host_ok;
        int         next_val;

        c        = it.char_code;
        is_num   = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        is_alpha = ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
                   ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
        done     = 1'b0;
        res      = '0;

        if (name_len == 0)
            first_digit = is_num;
        if (name_len != NAME_LEN_SAT)
            name_len++;

        if (c == CHAR_DOT) begin
            // closes a label and an octet
            if (label_cnt == 0 || label_cnt > MAX_LABEL_LEN || prev_char == CHAR_HYPHEN)
                host_bad = 1'b1;
            label_cnt   = '0;
            letter_seen = 1'b0;
            if (octet_cnt == 0 || dots >= QUAD_DOTS)
                ip_bad = 1'b1;
            addr_acc  = {addr_acc[23:0], octet_val[7:0]};
            octet_val = '0;
            octet_cnt = '0;
            if (dots != DOT_SAT)
                dots++;
        end else if (c == CHAR_HYPHEN) begin
            if (label_cnt == 0)
                host_bad = 1'b1;
            if (label_cnt != LABEL_LEN_SAT)
                label_cnt++;
            ip_bad = 1'b1;
        end else if (is_num || is_alpha) begin
            if (label_cnt != LABEL_LEN_SAT)
                label_cnt++;
            if (is_alpha) begin
                letter_seen = 1'b1;
                ip_bad      = 1'b1;
            end else begin
                next_val = int'(octet_val) * 10 + int'(c - CHAR_ZERO);
                // leading zero
                if (octet_cnt != 0 && octet_val == 0)
                    ip_bad = 1'b1;
                if (next_val > 255)
                    ip_bad = 1'b1;
                else
                    octet_val = next_val[8:0];
                if (octet_cnt != DIGIT_SAT)
                    octet_cnt++;
            end
        end else begin
            host_bad = 1'b1;
            ip_bad   = 1'b1;
        end
        prev_char = c;

        if (it.last_char) begin
            ip_ok   = !ip_bad && octet_cnt != 0 && dots == QUAD_DOTS;
            host_ok = !host_bad && name_len <= MAX_NAME_LEN && label_cnt != 0 &&
                      label_cnt <= MAX_LABEL_LEN && c != CHAR_HYPHEN &&
                      !(dots != 0 && !letter_seen);
            if (ip_ok) begin
                res.verdict      = VERDICT_IPV4_OK;
                res.ipv4_address = {addr_acc[23:0], octet_val[7:0]};
            end else if (dots == QUAD_DOTS && first_digit && is_num) begin
                res.verdict = VERDICT_IPV4_BAD;
            end else if (host_ok) begin
                res.verdict = VERDICT_HOST_OK;
            end else begin
                res.verdict = VERDICT_INVALID;
            end
            done = 1'b1;
            clear_name_state();
        end
    endtask

    // Results first: one leaving now belongs to a name finished earlier
    always @(posedge clk or negedge rst_n) begin : watch
        bit           have_verdict;
        result_item_t predicted;
        result_item_t due;

        if (!rst_n) begin
            clear_name_state();
            expected_verdicts.delete();
            fail_count    = 0;
            verdicts_owed = 0;
        end else begin
            if (result_valid && result_ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("verdict %0d with no name finished",
                                              result_data.verdict));
                end else begin
                    due = expected_verdicts.pop_front();
                    if (result_data.verdict !== due.verdict)
                        report_mismatch($sformatf("verdict: got %0d, want %0d",
                                                  result_data.verdict, due.verdict));
                    if (result_data.ipv4_address !== due.ipv4_address)
                        report_mismatch($sformatf("ipv4_address: got %08h, want %08h",
                                                  result_data.ipv4_address,
                                                  due.ipv4_address));
                end
            end
            if (char_valid && char_ready) begin
                classify_byte(char_data, have_verdict, predicted);
                if (have_verdict)
                    expected_verdicts.push_back(predicted);
            end
            verdicts_owed = expected_verdicts.size();
        end
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the classifier whole names byte by byte: short directed names first,
// then random dotted quads, broken quads, hostnames, broken hostnames, noise
// and a few very long names, under phases of sender idling and receiver
// stalls. A side checker predicts and compares every verdict.
// ----------------------------------------------------------------------------
module testbench;
    import ihc_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         char_valid;
    logic         char_ready;
    char_item_t   char_data;
    logic         result_valid;
    logic         result_ready;
    result_item_t result_data;

    int fail_count;
    int verdicts_owed;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int bytes_sent;

    // Bytes of the name being built
    logic [7:0] name_buf[$];

    ipv4_or_hostname_classifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    ihc_verdict_checker verdict_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_ready    (char_ready),
        .char_data     (char_data),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result_data   (result_data),
        .fail_count    (fail_count),
        .verdicts_owed (verdicts_owed)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #8_000_000;
        $display("ipv4_or_hostname_classifier test failed");
        $finish;
    end

    // Receiver: long hold-off when asked, random stalls otherwise
    initial
    begin : receiver
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return CHAR_ZERO + 8'($urandom_range(9));
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            name_buf.push_back(s[i]);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    // Valid stays high into the next item unless that item idles first.
    task automatic push_byte(input logic [7:0] c, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= '{char_code: c, last_char: is_last};
        do
            @(posedge clk);
        while (!char_ready);
        @(negedge clk);
    endtask

    task automatic send_name();
        if (name_buf.size() == 0)
            name_buf.push_back(rand_letter());
        for (int i = 0; i < name_buf.size(); i++)
        begin
            push_byte(name_buf[i], i == name_buf.size() - 1);
            bytes_sent++;
        end
        name_buf.delete();
    endtask

    function automatic int pick_octet();
        case ($urandom_range(5))
            0: return 0;
            1: return 255;
            2: return $urandom_range(1, 9);
            3: return $urandom_range(10, 99);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // One octet that breaks the strict dotted-quad rules, or a random byte that may not
    task automatic add_bad_octet();
        case ($urandom_range(7))
            0: add_text($sformatf("0%0d", $urandom_range(0, 255)));
            1: add_text($sformatf("%0d", $urandom_range(256, 999)));
            2: ;  // empty octet
            3: add_text($sformatf("%0d", $urandom_range(1000, 99999)));
            4:
            begin
                name_buf.push_back(rand_digit());
                name_buf.push_back(rand_letter());
            end
            5:
            begin
                name_buf.push_back(rand_digit());
                name_buf.push_back(CHAR_HYPHEN);
                name_buf.push_back(rand_digit());
            end
            6: name_buf.push_back(8'($urandom_range(255)));
            default: add_text("256");
        endcase
    endtask

    task automatic add_dotted(input bit broken);
        int nparts;
        int bad_idx;

        nparts  = 4;
        bad_idx = -1;
        if (broken)
        begin
            case ($urandom_range(7))
                0: nparts = 3;
                1: nparts = 5;
                2: nparts = $urandom_range(8, 12);  // dot count saturates
                default: nparts = 4;
            endcase
            if (nparts == 4 || $urandom_range(1))
                bad_idx = $urandom_range(nparts - 1);
        end
        for (int i = 0; i < nparts; i++)
        begin
            if (i != 0)
                name_buf.push_back(CHAR_DOT);
            if (i == bad_idx)
                add_bad_octet();
            else
                add_text($sformatf("%0d", pick_octet()));
        end
    endtask

    // Label of letters and digits, hyphens only inside
    task automatic add_label(input int n, input bit need_letter);
        int spot;

        spot = $urandom_range(n - 1);
        for (int i = 0; i < n; i++)
        begin
            if (need_letter && i == spot)
                name_buf.push_back(rand_letter());
            else if (i > 0 && i < n - 1 && $urandom_range(5) == 0)
                name_buf.push_back(CHAR_HYPHEN);
            else if ($urandom_range(2) == 0)
                name_buf.push_back(rand_digit());
            else
                name_buf.push_back(rand_letter());
        end
    endtask

    task automatic add_hostname();
        int nlab;
        int len;

        nlab = $urandom_range(1, 4);
        for (int l = 0; l < nlab; l++)
        begin
            if (l != 0)
                name_buf.push_back(CHAR_DOT);
            len = ($urandom_range(15) == 0) ? $urandom_range(60, 63) : $urandom_range(1, 10);
            // top label needs a letter; now and then leave it to chance
            add_label(len, l == nlab - 1 && nlab > 1 && $urandom_range(7) != 0);
        end
    endtask

    task automatic break_hostname();
        int pos;

        pos = $urandom_range(name_buf.size() - 1);
        case ($urandom_range(7))
            0: name_buf[pos] = 8'($urandom_range(255));
            1: name_buf.push_front(CHAR_DOT);
            2: name_buf.push_back(CHAR_DOT);
            3: name_buf.insert(pos, CHAR_DOT);
            4: name_buf.push_front(CHAR_HYPHEN);
            5: name_buf.push_back(CHAR_HYPHEN);
            6:
            begin
                // label one or more bytes over the limit
                name_buf.push_front(CHAR_DOT);
                repeat ($urandom_range(64, 70))
                    name_buf.push_front(rand_letter());
            end
            default: name_buf.insert(pos, CHAR_HYPHEN);
        endcase
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 12))
        begin
            case ($urandom_range(4))
                0: name_buf.push_back(CHAR_DOT);
                1: name_buf.push_back(CHAR_HYPHEN);
                2: name_buf.push_back(rand_digit());
                3: name_buf.push_back(rand_letter());
                default: name_buf.push_back(8'($urandom_range(255)));
            endcase
        end
    endtask

    // Names around the length limit; flat ones also saturate the label count
    task automatic add_long_name();
        int  target;
        bit  flat;

        case ($urandom_range(5))
            0: target = 252;
            1: target = 253;
            2: target = 254;
            3: target = 255;
            4: target = 256;
            default: target = $urandom_range(257, 300);
        endcase
        flat = ($urandom_range(3) == 0);
        for (int i = 0; i < target; i++)
        begin
            if (!flat && i % 64 == 63)
                name_buf.push_back(CHAR_DOT);
            else
                name_buf.push_back(rand_letter());
        end
    endtask

    task automatic send_random_name();
        int r;

        r = $urandom_range(99);
        if (r < 25)
            add_dotted(1'b0);
        else if (r < 42)
            add_dotted(1'b1);
        else if (r < 66)
            add_hostname();
        else if (r < 83)
        begin
            add_hostname();
            break_hostname();
        end
        else if (r < 99)
            add_noise();
        else
            add_long_name();
        send_name();
    endtask

    // Short names: single bytes of each class, zero and top byte, quads, a zero byte inside
    task automatic send_directed();
        add_text("9");
        send_name();
        name_buf.push_back(8'h00);
        send_name();
        name_buf.push_back(8'hFF);
        send_name();
        add_text("z");
        send_name();
        name_buf.push_back(CHAR_HYPHEN);
        send_name();
        name_buf.push_back(CHAR_DOT);
        send_name();
        add_text("0.0.0.0");
        send_name();
        add_text("1.2.3.04");
        send_name();
        // zero byte inside a name does not end it
        name_buf.push_back(rand_letter());
        name_buf.push_back(8'h00);
        name_buf.push_back(rand_letter());
        send_name();
    endtask

    initial
    begin : stimulus
        int quota;

        rst_n          = 1'b0;
        char_valid     = 1'b0;
        char_data      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        bytes_sent     = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_directed();

        // Phases: no idling but a long receiver hold-off, sender idle, receiver stalls, both lightly
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_left      = 250;  // sender keeps offering, block backs up
                end
                1:
                begin
                    send_idle_pct  = 85;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 85;
                end
                default:
                begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            quota = bytes_sent + 480;
            while (bytes_sent < quota)
                send_random_name();
        end
        char_valid <= 1'b0;

        // Drain, then wait on for anything unexpected
        while (verdicts_owed != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (fail_count == 0 && verdicts_owed == 0)
            $display("ipv4_or_hostname_classifier test passed");
        else
            $display("ipv4_or_hostname_classifier test failed");
        $finish;
    end

endmodule
